// File: hdl/relation_consistency_union_find_top_assert.svh
// Assertion macros for the relation consistency checker.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef RELATION_CONSISTENCY_UNION_FIND_TOP_ASSERT_SVH
`define RELATION_CONSISTENCY_UNION_FIND_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RCU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define RCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rcuf_pkg.sv
// Shared types and constants for the relation consistency checker.
// No dependencies.
`default_nettype none
package rcuf_pkg;
  localparam int unsigned MaxAnimalsDefault = 16384;
  localparam int unsigned CountW = 15;
  localparam int unsigned IdxW   = 16;
  localparam int unsigned TotW   = 32;

  typedef struct packed {
    logic            op;
    logic [IdxW-1:0] first_animal;
    logic [IdxW-1:0] second_animal;
  } rcuf_in_t;

  typedef struct packed {
    logic            is_false;
    logic [TotW-1:0] false_count;
  } rcuf_out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK,
    S_F_RD, S_F_WAIT, S_F_STEP,
    S_C_RD, S_C_WAIT, S_C_STEP,
    S_J_NEXT, S_U_SIZE, S_U_WAIT, S_U_WRITE, S_DONE
  } rcuf_state_e;

  // Datapath commands.
  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic load_find;
    logic rd_parent;
    logic walk_up;
    logic comp_write;
    logic save_root;
    logic pair_next;
    logic rd_size;
    logic link;
    logic finish;
  } rcuf_cmd_t;

  // Datapath status.
  typedef struct packed {
    logic clear_last;
    logic range_bad;
    logic at_root;
    logic walk_at_root;
    logic second_half;
    logic pair_last;
    logic check_phase;
    logic hit;
  } rcuf_sts_t;
endpackage
`default_nettype wire

// File: hdl/rcuf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rcuf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: hdl/rcuf_datapath.sv
// Datapath: node tables, find walker, union, and false counter.
// Depends on rcuf_pkg and rcuf_ram.
`default_nettype none
module rcuf_datapath import rcuf_pkg::*; #(
  parameter int unsigned MaxAnimals = MaxAnimalsDefault
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  rcuf_cmd_t       cmd_i,
  output rcuf_sts_t       sts_o,
  input  rcuf_in_t        item_i,
  input  wire [CountW-1:0] animal_count_i,
  output rcuf_out_t       result_o
);
  localparam int unsigned Nodes = 3 * MaxAnimals;
  localparam int unsigned NodeW = $clog2(Nodes);
  localparam logic [NodeW-1:0] MOff  = NodeW'(MaxAnimals);
  localparam logic [NodeW-1:0] M2Off = NodeW'(2 * MaxAnimals);
  localparam logic [NodeW-1:0] LastNode = NodeW'(Nodes - 1);
  localparam logic [IdxW:0] MaxLim = (IdxW+1)'(MaxAnimals);

  logic [NodeW-1:0] clr_q, xs_q, ys_q, cur_q, walk_q, start_q, root_q, ra_q;
  logic             op_q, bad_q, half_q, hit_q;
  logic [2:0]       pair_q;
  logic [TotW-1:0]  tot_q;
  logic [IdxW-1:0]  size_a_q;
  logic [15:0]      par_rd, size_rd;

  // Pair table: operands of each join check or union.
  logic [NodeW-1:0] op_a, op_b;
  always_comb begin
    op_a = xs_q;
    op_b = ys_q;
    case ({op_q, pair_q})
      4'b0_000: begin op_a = xs_q + MOff;  op_b = ys_q; end
      4'b0_001: begin op_a = ys_q + MOff;  op_b = xs_q; end
      4'b0_010: begin op_a = xs_q + M2Off; op_b = ys_q; end
      4'b0_011: begin op_a = ys_q + M2Off; op_b = xs_q; end
      4'b0_100: begin op_a = xs_q;         op_b = ys_q; end
      4'b0_101: begin op_a = xs_q + MOff;  op_b = ys_q + MOff; end
      4'b0_110: begin op_a = xs_q + M2Off; op_b = ys_q + M2Off; end
      4'b1_000: begin op_a = xs_q;         op_b = ys_q; end
      4'b1_001: begin op_a = ys_q + MOff;  op_b = xs_q; end
      4'b1_010: begin op_a = xs_q + M2Off; op_b = ys_q; end
      4'b1_100: begin op_a = xs_q + MOff;  op_b = ys_q; end
      4'b1_101: begin op_a = ys_q + M2Off; op_b = xs_q; end
      4'b1_110: begin op_a = ys_q + MOff;  op_b = xs_q + M2Off; end
      default: ;
    endcase
  end

  // Range check of the incoming item.
  logic [IdxW:0] lim;
  always_comb begin
    lim = {1'b0, animal_count_i};
    if (lim > MaxLim) lim = MaxLim;
  end
  logic in_bad;
  assign in_bad = (item_i.first_animal == '0) || (item_i.second_animal == '0) ||
                  ({1'b0, item_i.first_animal} > lim) ||
                  ({1'b0, item_i.second_animal} > lim);

  // Memory ports.
  logic             p_we, s_we;
  logic [NodeW-1:0] p_wa, p_ra, s_wa, s_ra;
  logic [15:0]      p_wd, s_wd;
  logic [IdxW-1:0]  size_sum;
  assign size_sum = size_a_q + size_rd;
  always_comb begin
    p_we = 1'b0; p_wa = clr_q; p_wd = 16'(clr_q);
    s_we = 1'b0; s_wa = clr_q; s_wd = 16'd1;
    if (cmd_i.clear_step) begin
      p_we = 1'b1; s_we = 1'b1;
    end else if (cmd_i.comp_write) begin
      p_we = 1'b1; p_wa = walk_q; p_wd = 16'(root_q);
    end else if (cmd_i.link) begin
      // Larger set keeps root; tie keeps the first operand's root.
      p_we = 1'b1; s_we = 1'b1;
      if (size_a_q < size_rd) begin
        p_wa = ra_q; p_wd = 16'(root_q); s_wa = root_q;
      end else begin
        p_wa = root_q; p_wd = 16'(ra_q); s_wa = ra_q;
      end
      s_wd = size_sum;
    end
    p_ra = cmd_i.walk_up ? walk_q : cur_q;
    s_ra = cmd_i.rd_size ? root_q : ra_q;
  end

  rcuf_ram #(.Width(16), .Depth(Nodes)) u_parent (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .raddr_i(p_ra), .rdata_o(par_rd));
  rcuf_ram #(.Width(16), .Depth(Nodes)) u_size (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd),
    .raddr_i(s_ra), .rdata_o(size_rd));

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; tot_q <= '0; pair_q <= '0; half_q <= 1'b0;
      bad_q <= 1'b0; hit_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.load_item) begin
        pair_q <= '0; half_q <= 1'b0; bad_q <= in_bad;
      end
      if (cmd_i.save_root) begin
        if (!half_q) begin
          ra_q <= root_q; half_q <= 1'b1;
        end else begin
          half_q <= 1'b0;
          hit_q  <= (ra_q == root_q);
          if (!pair_q[2] && ra_q == root_q) bad_q <= 1'b1;
        end
      end
      if (cmd_i.pair_next) begin
        if (!pair_q[2] && (pair_q == 3'd3 || (op_q && pair_q == 3'd2)))
          pair_q <= 3'd4;
        else
          pair_q <= pair_q + 1'b1;
      end
      if (cmd_i.finish && bad_q && tot_q != '1) tot_q <= tot_q + 1'b1;
    end
  end

  // Payload registers of the walker.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q <= item_i.op;
      xs_q <= NodeW'(item_i.first_animal - 1'b1);
      ys_q <= NodeW'(item_i.second_animal - 1'b1);
    end
    // The first find of a pair starts at operand a, the second, issued
    // together with saving the first root, at operand b.
    if (cmd_i.load_find) begin
      cur_q <= cmd_i.save_root ? op_b : op_a;
      start_q <= cmd_i.save_root ? op_b : op_a;
    end
    // Root walk: follow parents until a self loop.
    if (sts_o.at_root == 1'b0 && !cmd_i.walk_up && !cmd_i.load_find && cmd_i.rd_parent)
      cur_q <= NodeW'(par_rd);
    if (sts_o.at_root && cmd_i.rd_parent && !cmd_i.walk_up) begin
      root_q <= cur_q; walk_q <= start_q;
    end
    if (cmd_i.comp_write) walk_q <= NodeW'(par_rd);
    if (cmd_i.rd_size) size_a_q <= size_rd;
  end

  assign sts_o.clear_last   = (clr_q == LastNode);
  assign sts_o.range_bad    = bad_q;
  assign sts_o.at_root      = (NodeW'(par_rd) == cur_q);
  assign sts_o.walk_at_root = (walk_q == root_q);
  assign sts_o.second_half  = half_q;
  assign sts_o.pair_last    = (pair_q == 3'd6);
  assign sts_o.check_phase  = !pair_q[2];
  assign sts_o.hit          = hit_q;

  assign result_o.is_false    = bad_q;
  assign result_o.false_count = (bad_q && tot_q != '1) ? tot_q + 1'b1 : tot_q;
endmodule
`default_nettype wire

// File: hdl/rcuf_ctrl.sv
// Controller state machine sequencing finds, checks and unions.
// Depends on rcuf_pkg.
`default_nettype none
module rcuf_ctrl import rcuf_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  output logic       busy_o,
  output logic       done_o,
  output rcuf_cmd_t  cmd_o,
  input  rcuf_sts_t  sts_i
);
  rcuf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.range_bad) state_d = S_DONE;
        else begin
          cmd_o.load_find = 1'b1;
          state_d = S_F_RD;
        end
      end
      S_F_RD: state_d = S_F_WAIT;
      S_F_WAIT: state_d = S_F_STEP;
      S_F_STEP: begin
        // Parent of cur is on the read port.
        cmd_o.rd_parent = 1'b1;
        if (sts_i.at_root) state_d = S_C_RD;
        else state_d = S_F_WAIT;
      end
      S_C_RD: begin
        cmd_o.walk_up = 1'b1;
        if (sts_i.walk_at_root) begin
          state_d = S_J_NEXT;
        end else state_d = S_C_WAIT;
      end
      S_C_WAIT: begin
        cmd_o.walk_up = 1'b1;
        state_d = S_C_STEP;
      end
      S_C_STEP: begin
        // Point the node at the root and move to its old parent.
        cmd_o.walk_up = 1'b1;
        cmd_o.comp_write = 1'b1;
        state_d = S_C_RD;
      end
      S_J_NEXT: begin
        cmd_o.save_root = 1'b1;
        if (!sts_i.second_half) begin
          cmd_o.load_find = 1'b1;
          state_d = S_F_RD;
        end else if (!sts_i.check_phase) state_d = S_U_SIZE;
        else begin
          // Check pairs: advance; S_CHECK stops on a hit recorded here.
          cmd_o.pair_next = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_U_SIZE: begin
        state_d = S_U_WAIT;
      end
      S_U_WAIT: begin
        cmd_o.rd_size = 1'b1;
        state_d = S_U_WRITE;
      end
      S_U_WRITE: begin
        if (!sts_i.hit) cmd_o.link = 1'b1;
        cmd_o.pair_next = 1'b1;
        if (sts_i.pair_last) state_d = S_DONE;
        else begin
          state_d = S_CHECK;
        end
      end
      S_DONE: begin
        done_o = 1'b1;
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/relation_consistency_union_find_top.sv
// Top level of the relation consistency checker: APB register, control, datapath.
// Depends on rcuf_pkg, rcuf_ctrl, rcuf_datapath and the assertion header.
`default_nettype none
// A statement is taken when start_i is high and busy_o is low; its single result
// appears for one cycle with done_o and cannot be held off, so the receiver must
// take it then. After reset the block initializes its node tables with busy_o
// high. A statement naming an animal out of range goes from S_CHECK straight to
// S_DONE for its result. Otherwise the time is data dependent: each find reads
// its start node and walks up one tree level at a time, then compresses the path
// node by node; each check pair or union adds a step, and each union reads sizes
// and links. Up to fourteen finds run per statement.
`include "relation_consistency_union_find_top_assert.svh"
module relation_consistency_union_find_top import rcuf_pkg::*; #(
  parameter int unsigned MaxAnimals = MaxAnimalsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  rcuf_in_t    item_i,
  output logic        done_o,
  output rcuf_out_t   result_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [1:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [1:0] AddrCount = 2'd0;
  logic [CountW-1:0] count_q;
  rcuf_cmd_t cmd;
  rcuf_sts_t sts;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= CountW'(16384);
    else if (psel && penable && pwrite && paddr == AddrCount) count_q <= pwdata[CountW-1:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == AddrCount) ? {{(32-CountW){1'b0}}, count_q} : '0;

  rcuf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .cmd_o(cmd), .sts_i(sts));

  rcuf_datapath #(.MaxAnimals(MaxAnimals)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .item_i,
    .animal_count_i(count_q), .result_o);

  `RCU_ASSERT_IMP(a_done_busy, done_o, busy_o, "result outside a busy period")
  `RCU_ASSERT_NEXT(a_done_idle, done_o, !busy_o, "block not idle after result")
  `RCU_ASSERT_IMP(a_cnt_mono, done_o && result_o.is_false && $past(result_o.false_count) != '1,
    result_o.false_count != '0, "false count lost")
endmodule
`default_nettype wire

// File: bench/tb_relation_consistency_union_find_top.sv
// Testbench for the relation consistency checker: statements in, verdicts out.
// Depends on rcuf_pkg and relation_consistency_union_find_top; predicts each verdict
// with its own three-domain union-find and checks every result beat in order.
`timescale 1ns / 100ps

module tb_relation_consistency_union_find_top;
  import rcuf_pkg::*;

  localparam int unsigned Animals = MaxAnimalsDefault;
  localparam int unsigned Nodes = 3 * Animals;
  localparam logic [1:0] AddrAnimalCount = 2'd0;
  localparam logic OpSame = 1'b0;
  localparam logic OpEats = 1'b1;

  // Verdict predictor and store of pending verdicts.
  class verdict_board;
    logic [15:0] parent_q[Nodes];
    logic [15:0] size_q[Nodes];
    logic [31:0] false_total;
    int unsigned animal_limit;
    rcuf_out_t pending[$];
    int errors;

    function void clear_all();
      for (int i = 0; i < Nodes; i++) begin
        parent_q[i] = i[15:0];
        size_q[i] = 16'd1;
      end
      false_total = '0;
      animal_limit = 16384;
      errors = 0;
    endfunction

    function void set_count(logic [14:0] v);
      animal_limit = v;
    endfunction

    function int unsigned root_of(int unsigned n);
      int unsigned r;
      int unsigned w;
      int unsigned up;
      r = n;
      while (parent_q[r] != r) r = parent_q[r];
      w = n;
      while (w != r) begin
        up = parent_q[w];
        parent_q[w] = r[15:0];
        w = up;
      end
      return r;
    endfunction

    function bit joined(int unsigned a, int unsigned b);
      int unsigned ra;
      ra = root_of(a);
      return ra == root_of(b);
    endfunction

    function void merge(int unsigned a, int unsigned b);
      int unsigned ra;
      int unsigned rb;
      int unsigned t;
      ra = root_of(a);
      rb = root_of(b);
      if (ra == rb) return;
      if (size_q[ra] < size_q[rb]) begin
        t = ra; ra = rb; rb = t;
      end
      parent_q[rb] = ra[15:0];
      size_q[ra] = size_q[ra] + size_q[rb];
    endfunction

    // Note an accepted statement and queue its verdict.
    function void note_statement(rcuf_in_t it);
      int unsigned lim;
      int unsigned x;
      int unsigned y;
      bit bad;
      rcuf_out_t res;
      lim = (animal_limit > Animals) ? Animals : animal_limit;
      x = it.first_animal;
      y = it.second_animal;
      if (x == 0 || y == 0 || x > lim || y > lim) begin
        bad = 1'b1;
      end else begin
        x = x - 1;
        y = y - 1;
        if (it.op == OpSame) begin
          bad = joined(x + Animals, y) || joined(y + Animals, x) ||
                joined(x + 2 * Animals, y) || joined(y + 2 * Animals, x);
          if (!bad) begin
            merge(x, y);
            merge(x + Animals, y + Animals);
            merge(x + 2 * Animals, y + 2 * Animals);
          end
        end else begin
          bad = joined(x, y) || joined(y + Animals, x) || joined(x + 2 * Animals, y);
          if (!bad) begin
            merge(x + Animals, y);
            merge(y + 2 * Animals, x);
            merge(y + Animals, x + 2 * Animals);
          end
        end
      end
      if (bad && false_total != 32'hFFFF_FFFF) false_total++;
      res.is_false = bad;
      res.false_count = false_total;
      pending.push_back(res);
    endfunction

    // Compare one result beat with the oldest pending verdict.
    function void check_verdict(rcuf_out_t got);
      rcuf_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result is_false=%0b false_count=%0d",
                 $time, got.is_false, got.false_count);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.is_false !== exp.is_false) begin
        $display("%0t: is_false expected %0b actual %0b", $time, exp.is_false, got.is_false);
        errors++;
      end
      if (got.false_count !== exp.false_count) begin
        $display("%0t: false_count expected %0d actual %0d",
                 $time, exp.false_count, got.false_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  rcuf_in_t item_i = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy_o;
  logic done_o;
  rcuf_out_t result_o;
  logic [31:0] prdata;
  logic pready;

  verdict_board board;
  int unsigned gap_pct;
  int unsigned cur_limit;

  relation_consistency_union_find_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check every result beat at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_verdict(result_o);
  end

  // Hard limit on run length, including the table clearing after reset.
  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  // Drive one statement beat, idling first at the current rate. Start stays
  // high after the beat is taken until the next idle cycle or drain.
  task automatic send_statement(logic op, logic [15:0] a, logic [15:0] b);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= '{op: op, first_animal: a, second_animal: b};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_statement(item_i);
  endtask

  // Wait until all verdicts are in plus a settling margin.
  task automatic drain();
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Write the animal count register while the block is idle.
  task automatic write_count(logic [14:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrAnimalCount;
    pwdata <= {17'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_count(v);
    cur_limit = v;
  endtask

  // Index mostly in range, sometimes zero, just above the limit or anywhere.
  function automatic logic [15:0] pick_animal(int unsigned lim);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return 16'd0;
    if (r < 6) return 16'(lim + 1);
    if (r < 9) return 16'($urandom);
    if (lim == 0) return 16'd1;
    if (r < 60) return 16'($urandom_range(lim < 24 ? lim : 24, 1));
    return 16'($urandom_range(lim, 1));
  endfunction

  task automatic random_phase(int n, int unsigned pct);
    logic [15:0] a;
    gap_pct = pct;
    for (int i = 0; i < n; i++) begin
      a = pick_animal(cur_limit);
      send_statement(1'($urandom_range(1)), a, ($urandom_range(9) == 0) ? a :
                     pick_animal(cur_limit));
    end
  endtask

  initial begin
    board = new();
    board.clear_all();
    cur_limit = 16384;
    gap_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range edges, self relations, contradictions of both kinds.
    send_statement(OpSame, 16'd0, 16'd1);
    send_statement(OpEats, 16'd1, 16'd0);
    send_statement(OpSame, 16'd16384, 16'd16384);
    send_statement(OpEats, 16'd16385, 16'd1);
    send_statement(OpEats, 16'hFFFF, 16'hFFFF);
    send_statement(OpEats, 16'd5, 16'd5);
    send_statement(OpEats, 16'd1, 16'd2);
    send_statement(OpEats, 16'd2, 16'd1);
    send_statement(OpSame, 16'd1, 16'd2);
    send_statement(OpEats, 16'd2, 16'd3);
    send_statement(OpEats, 16'd3, 16'd1);
    send_statement(OpEats, 16'd1, 16'd3);
    send_statement(OpSame, 16'd4, 16'd1);
    send_statement(OpSame, 16'd4, 16'd3);
    send_statement(OpEats, 16'd4, 16'd2);
    send_statement(OpSame, 16'd16384, 16'd1);
    send_statement(OpEats, 16'h5555, 16'hAAAA);
    write_count(15'd0);
    send_statement(OpSame, 16'd1, 16'd1);
    write_count(15'h7FFF);
    send_statement(OpSame, 16'd16384, 16'd16383);
    send_statement(OpEats, 16'd16385, 16'd2);

    // Random phases across several counts; sender gaps at varying rates, then none.
    write_count(15'd1);
    random_phase(40, 23);
    write_count(15'd20);
    random_phase(400, 23);
    drain();
    write_count(15'd200);
    random_phase(400, 68);
    write_count(15'd16384);
    random_phase(200, 0);
    write_count(15'd12);
    random_phase(260, 0);

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
